// ===== rtl/imht_pkg.sv =====
// Shared types, widths, codes and helper functions of the image map hit test unit.
package imht_pkg;

  localparam int COORD_BITS = 16;
  localparam int TARGET_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = COORD_BITS;
  localparam int SQ_BITS = 2 * COORD_BITS;
  localparam int DIST_BITS = 2 * COORD_BITS + 1;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TARGET_BITS-1:0] target_t;
  typedef logic [SQ_BITS-1:0] square_t;
  typedef logic [DIST_BITS-1:0] dist_t;

  typedef enum logic [2:0] {
    OP_CIRCLE_RADIUS = 3'd0,
    OP_CIRCLE_EDGE   = 3'd1,
    OP_RECT          = 3'd2,
    OP_VERTEX        = 3'd3,
    OP_POINT         = 3'd4,
    OP_DEFAULT       = 3'd5,
    OP_END           = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    OUTCOME_HIT      = 2'd0,
    OUTCOME_FALLBACK = 2'd1,
    OUTCOME_NONE     = 2'd2
  } outcome_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLICK_X = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLICK_Y = CFG_INDEX_BITS'(1);

  typedef struct packed {
    logic                        span;
    logic signed [PROD_BITS-1:0] lhs;
    logic signed [PROD_BITS-1:0] rhs;
  } crossing_t;

  function automatic coord_t abs_diff(coord_t a, coord_t b);
    abs_diff = (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  // Span test and both cross products of the rightward-ray test for one edge.
  function automatic crossing_t edge_cross(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                           coord_t px, coord_t py);
    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic signed [DIFF_BITS-1:0] ex;
    logic signed [DIFF_BITS-1:0] ey;
    crossing_t c;
    dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
    ex = $signed({1'b0, px}) - $signed({1'b0, x0});
    ey = $signed({1'b0, py}) - $signed({1'b0, y0});
    if (dy < 0) begin
      dx = -dx;
      dy = -dy;
    end
    c.span = ((y0 > py) && (y1 < py)) || ((y1 > py) && (y0 < py));
    c.lhs = PROD_BITS'(ey) * PROD_BITS'(dx);
    c.rhs = PROD_BITS'(ex) * PROD_BITS'(dy);
    edge_cross = c;
  endfunction

endpackage

// ===== rtl/imht_if.sv =====
// Valid/ready channel interfaces for region items and hit test results.
interface imht_item_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  imht_pkg::coord_t     ax;
  imht_pkg::coord_t     ay;
  imht_pkg::coord_t     bx;
  imht_pkg::coord_t     by;
  imht_pkg::coord_t     radius;
  imht_pkg::target_t    target;
  logic                 last_vertex;

  modport source(output valid, operation, ax, ay, bx, by, radius, target, last_vertex,
                 input ready);
  modport sink(input valid, operation, ax, ay, bx, by, radius, target, last_vertex,
               output ready);
endinterface

interface imht_result_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           outcome;
  imht_pkg::target_t    chosen_target;

  modport source(output valid, outcome, chosen_target, input ready);
  modport sink(input valid, outcome, chosen_target, output ready);
endinterface

// ===== rtl/image_map_hit_test_unit.sv =====
// Image map hit test: resolves the configured click point against a stream of regions.
// Result path: an end item passes the input register and then the result register.
// Throughput: one item per cycle unless an end item is stalled; each item is decided in a
// single pass between the input register and the region state and result registers.
// Stalls: an end item holds in the input register while the previous result is not taken.
// Reset: synchronous rst clears the input register valid bit, all region state and the click registers.
module image_map_hit_test_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [imht_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [imht_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  imht_item_if.sink                           item,
  imht_result_if.source                       result
);

  imht_pkg::coord_t click_x;
  imht_pkg::coord_t click_y;

  // input register
  logic              s1_valid;
  logic [2:0]        s1_op;
  imht_pkg::coord_t  s1_ax;
  imht_pkg::coord_t  s1_ay;
  imht_pkg::coord_t  s1_bx;
  imht_pkg::coord_t  s1_by;
  imht_pkg::coord_t  s1_radius;
  imht_pkg::target_t s1_target;
  logic              s1_last;

  // polygon vertex tracking
  logic             poly_open;
  imht_pkg::coord_t poly_first_x;
  imht_pkg::coord_t poly_first_y;
  imht_pkg::coord_t poly_prev_x;
  imht_pkg::coord_t poly_prev_y;

  // region state
  logic              hit_seen;
  imht_pkg::target_t hit_target;
  logic              fallback_valid;
  imht_pkg::target_t fallback_target;
  logic              point_seen;
  imht_pkg::dist_t   best_distance;
  logic              poly_parity;

  logic              hit_seen_next;
  imht_pkg::target_t hit_target_next;
  logic              fallback_valid_next;
  imht_pkg::target_t fallback_target_next;
  logic              point_seen_next;
  imht_pkg::dist_t   best_distance_next;
  logic              poly_parity_next;

  logic              out_valid;
  logic [1:0]        out_outcome;
  imht_pkg::target_t out_target;
  logic [1:0]        outcome_next;
  imht_pkg::target_t target_next;

  logic out_free;
  logic s1_go;
  logic s1_fire;
  logic in_fire;

  assign out_free = !out_valid || result.ready;
  assign s1_go    = (s1_op != imht_pkg::OP_END) || out_free;
  assign s1_fire  = s1_valid && s1_go;
  assign item.ready = !s1_valid || s1_go;
  assign in_fire  = item.valid && item.ready;

  assign result.valid         = out_valid;
  assign result.outcome       = out_outcome;
  assign result.chosen_target = out_target;

  // geometry logic
  imht_pkg::coord_t    dxc;
  imht_pkg::coord_t    dyc;
  imht_pkg::coord_t    dxab;
  imht_pkg::coord_t    dyab;
  imht_pkg::coord_t    close_x;
  imht_pkg::coord_t    close_y;
  imht_pkg::crossing_t cross1;
  imht_pkg::crossing_t cross2;
  logic                rect_hit;
  imht_pkg::square_t   dxc2;
  imht_pkg::square_t   dyc2;
  imht_pkg::square_t   r2;
  imht_pkg::square_t   dabx2;
  imht_pkg::square_t   daby2;

  always_comb begin
    dxc  = imht_pkg::abs_diff(click_x, s1_ax);
    dyc  = imht_pkg::abs_diff(click_y, s1_ay);
    dxab = imht_pkg::abs_diff(s1_ax, s1_bx);
    dyab = imht_pkg::abs_diff(s1_ay, s1_by);
    rect_hit = (click_x >= s1_ax) && (click_x <= s1_bx) &&
               (click_y >= s1_ay) && (click_y <= s1_by);
    close_x = poly_open ? poly_first_x : s1_ax;
    close_y = poly_open ? poly_first_y : s1_ay;
    cross1 = imht_pkg::edge_cross(poly_prev_x, poly_prev_y, s1_ax, s1_ay, click_x, click_y);
    cross2 = imht_pkg::edge_cross(s1_ax, s1_ay, close_x, close_y, click_x, click_y);
    dxc2  = imht_pkg::SQ_BITS'(dxc) * imht_pkg::SQ_BITS'(dxc);
    dyc2  = imht_pkg::SQ_BITS'(dyc) * imht_pkg::SQ_BITS'(dyc);
    r2    = imht_pkg::SQ_BITS'(s1_radius) * imht_pkg::SQ_BITS'(s1_radius);
    dabx2 = imht_pkg::SQ_BITS'(dxab) * imht_pkg::SQ_BITS'(dxab);
    daby2 = imht_pkg::SQ_BITS'(dyab) * imht_pkg::SQ_BITS'(dyab);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_x <= '0;
      click_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        imht_pkg::CFG_CLICK_X: click_x <= imht_pkg::coord_t'(cfg_data);
        imht_pkg::CFG_CLICK_Y: click_y <= imht_pkg::coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (in_fire) begin
      s1_op     <= item.operation;
      s1_ax     <= item.ax;
      s1_ay     <= item.ay;
      s1_bx     <= item.bx;
      s1_by     <= item.by;
      s1_radius <= item.radius;
      s1_target <= item.target;
      s1_last   <= item.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_open    <= 1'b0;
      poly_first_x <= '0;
      poly_first_y <= '0;
      poly_prev_x  <= '0;
      poly_prev_y  <= '0;
    end else if (s1_fire) begin
      case (s1_op) inside
        imht_pkg::OP_VERTEX: begin
          if (!poly_open) begin
            poly_first_x <= s1_ax;
            poly_first_y <= s1_ay;
          end
          poly_prev_x <= s1_ax;
          poly_prev_y <= s1_ay;
          poly_open   <= !s1_last;
        end
        imht_pkg::OP_CIRCLE_RADIUS, imht_pkg::OP_CIRCLE_EDGE, imht_pkg::OP_RECT,
        imht_pkg::OP_POINT, imht_pkg::OP_DEFAULT, imht_pkg::OP_END: poly_open <= 1'b0;
        default: ;
      endcase
    end
  end

  // decision logic
  imht_pkg::dist_t dist_click;
  imht_pkg::dist_t dist_edge;
  logic            crosses1;
  logic            crosses2;
  logic            parity_run;

  always_comb begin
    dist_click = imht_pkg::DIST_BITS'(dxc2) + imht_pkg::DIST_BITS'(dyc2);
    dist_edge  = imht_pkg::DIST_BITS'(dabx2) + imht_pkg::DIST_BITS'(daby2);
    crosses1 = poly_open && cross1.span &&
               ($signed(cross1.lhs) > $signed(cross1.rhs));
    crosses2 = s1_last && cross2.span &&
               ($signed(cross2.lhs) > $signed(cross2.rhs));
    parity_run = (poly_open ? poly_parity : 1'b0) ^ crosses1;

    hit_seen_next        = hit_seen;
    hit_target_next      = hit_target;
    fallback_valid_next  = fallback_valid;
    fallback_target_next = fallback_target;
    point_seen_next      = point_seen;
    best_distance_next   = best_distance;
    poly_parity_next     = poly_parity;

    if (hit_seen) begin
      outcome_next = imht_pkg::OUTCOME_HIT;
      target_next  = hit_target;
    end else if (fallback_valid) begin
      outcome_next = imht_pkg::OUTCOME_FALLBACK;
      target_next  = fallback_target;
    end else begin
      outcome_next = imht_pkg::OUTCOME_NONE;
      target_next  = '0;
    end

    if (s1_op == imht_pkg::OP_END) begin
      hit_seen_next        = 1'b0;
      hit_target_next      = '0;
      fallback_valid_next  = 1'b0;
      fallback_target_next = '0;
      point_seen_next      = 1'b0;
      best_distance_next   = '0;
      poly_parity_next     = 1'b0;
    end else if (!hit_seen) begin
      case (s1_op)
        imht_pkg::OP_CIRCLE_RADIUS: begin
          poly_parity_next = 1'b0;
          if (dist_click <= imht_pkg::DIST_BITS'(r2)) begin
            hit_seen_next   = 1'b1;
            hit_target_next = s1_target;
          end
        end
        imht_pkg::OP_CIRCLE_EDGE: begin
          poly_parity_next = 1'b0;
          if (dist_edge >= dist_click) begin
            hit_seen_next   = 1'b1;
            hit_target_next = s1_target;
          end
        end
        imht_pkg::OP_RECT: begin
          poly_parity_next = 1'b0;
          if (rect_hit) begin
            hit_seen_next   = 1'b1;
            hit_target_next = s1_target;
          end
        end
        imht_pkg::OP_VERTEX: begin
          if (s1_last) begin
            poly_parity_next = 1'b0;
            if (parity_run ^ crosses2) begin
              hit_seen_next   = 1'b1;
              hit_target_next = s1_target;
            end
          end else begin
            poly_parity_next = parity_run;
          end
        end
        imht_pkg::OP_POINT: begin
          poly_parity_next = 1'b0;
          if (!point_seen || (dist_click < best_distance)) begin
            best_distance_next   = dist_click;
            fallback_target_next = s1_target;
            fallback_valid_next  = 1'b1;
          end
          point_seen_next = 1'b1;
        end
        imht_pkg::OP_DEFAULT: begin
          poly_parity_next = 1'b0;
          if (!point_seen) begin
            fallback_target_next = s1_target;
            fallback_valid_next  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_seen        <= 1'b0;
      hit_target      <= '0;
      fallback_valid  <= 1'b0;
      fallback_target <= '0;
      point_seen      <= 1'b0;
      best_distance   <= '0;
      poly_parity     <= 1'b0;
    end else if (s1_fire) begin
      hit_seen        <= hit_seen_next;
      hit_target      <= hit_target_next;
      fallback_valid  <= fallback_valid_next;
      fallback_target <= fallback_target_next;
      point_seen      <= point_seen_next;
      best_distance   <= best_distance_next;
      poly_parity     <= poly_parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && (s1_op == imht_pkg::OP_END)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && (s1_op == imht_pkg::OP_END)) begin
      out_outcome <= outcome_next;
      out_target  <= target_next;
    end
  end

endmodule

// ===== rtl/imht_checker.sv =====
// Port-level assertions for the image map hit test unit and their bind.
module imht_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_ready,
  input logic [2:0]              item_operation,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic [1:0]              result_outcome,
  input imht_pkg::target_t       result_chosen_target
);

  logic [2:0] pending;
  logic       end_in;
  logic       result_out;

  assign end_in     = item_valid && item_ready && (item_operation == imht_pkg::OP_END);
  assign result_out = result_valid && result_ready;

  // track end items whose results are not yet transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(end_in) - 3'(result_out);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_outcome) &&
    $stable(result_chosen_target))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_outcome == imht_pkg::OUTCOME_HIT) ||
    (result_outcome == imht_pkg::OUTCOME_FALLBACK) ||
    (result_outcome == imht_pkg::OUTCOME_NONE))
    else $error("result outcome out of range");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_outcome == imht_pkg::OUTCOME_NONE) |-> result_chosen_target == '0)
    else $error("empty outcome with nonzero target");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 3'd0)
    else $error("result without a pending end item");

  assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more end items in flight than pipeline stages");

endmodule

bind image_map_hit_test_unit imht_checker u_imht_checker (
  .clk                  (clk),
  .rst                  (rst),
  .item_valid           (item.valid),
  .item_ready           (item.ready),
  .item_operation       (item.operation),
  .result_valid         (result.valid),
  .result_ready         (result.ready),
  .result_outcome       (result.outcome),
  .result_chosen_target (result.chosen_target)
);
